// File: hw/rtl/tidt_pkg.sv
// ----------------------------------------------------------------------------
// tidt_pkg: shared types and constants for the timestamped id table
// Request and response payloads, the stored slot layout, operation and
// status codes, and the step byte mask helper.
// ----------------------------------------------------------------------------
`default_nettype none

package tidt_pkg;

    // Table geometry.
    localparam int TABLE_ENTRIES = 64;
    localparam int STEP_BYTES    = 8;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    // Request codes.
    localparam logic [1:0] REQ_CREATE  = 2'd0;
    localparam logic [1:0] REQ_REMOVE  = 2'd1;
    localparam logic [1:0] REQ_TICK    = 2'd2;
    localparam logic [1:0] REQ_RESOLVE = 2'd3;

    // Response status codes.
    localparam logic [2:0] ST_DONE  = 3'd0;
    localparam logic [2:0] ST_HIT   = 3'd1;
    localparam logic [2:0] ST_MISS  = 3'd2;
    localparam logic [2:0] ST_STALE = 3'd3;
    localparam logic [2:0] ST_FULL  = 3'd4;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] group_key;
        logic [63:0] time_ns;
        logic [31:0] job_number;
        logic [3:0]  step_length;
        logic [63:0] step_name;
        logic        task_present;
        logic [31:0] task_number;
    } tidt_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] found_job;
        logic [3:0]  found_step_length;
        logic [63:0] found_step_name;
        logic        found_task_present;
        logic [31:0] found_task;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] stale_total;
    } tidt_rsp_t;

    // One stored table entry.
    typedef struct packed {
        logic [63:0] key;
        logic [31:0] job;
        logic [3:0]  step_len;
        logic [63:0] step_bytes;
        logic        task_flag;
        logic [31:0] task_num;
        logic [63:0] created;
        logic [63:0] removed;
    } tidt_slot_t;

    // Keeps the first len bytes of a packed step name.
    function automatic logic [63:0] step_mask(input logic [3:0] len);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++)
        begin
            m[i*8 +: 8] = (4'(i) < len) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/timestamped_id_table_with_grace_unit.sv
// ----------------------------------------------------------------------------
// timestamped_id_table_with_grace_unit: id to job identity table
// Create, remove, tick and resolve requests over a 64-entry keyed table.
// ----------------------------------------------------------------------------
// Each request walks the table one entry per cycle through the read port of
// the slot memory, with one compare stage after it, and then a finish step
// applies its update and loads the response register. A tick always scans
// all TABLE_ENTRIES entries; create, remove and resolve stop at the matching
// entry. The block takes one request at a time, and a finished response waits
// in its own register, so a new request is taken while the previous response
// is still pending; the update of that next request holds until the response
// register is free. No clearing pass is needed after reset: entry use flags
// reset in flip-flops.
`default_nettype none

module timestamped_id_table_with_grace_unit
    import tidt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_we,
    input  wire logic [63:0] cfg_wdata,
    input  wire logic      req_valid,
    output logic           req_ready,
    input  wire tidt_req_t req_data,
    output logic           rsp_valid,
    input  wire logic      rsp_ready,
    output tidt_rsp_t      rsp_data
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t             state_reg;
    tidt_req_t          req_reg;
    logic [63:0]        grace_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic               issue_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;
    logic               cmp_valid_reg;
    logic               match_found_reg;
    logic [IDX_W-1:0]   match_idx_reg;
    logic               free_found_reg;
    logic [IDX_W-1:0]   free_idx_reg;
    tidt_slot_t         hit_data_reg;
    logic [TABLE_ENTRIES-1:0] used_reg;
    logic [TABLE_ENTRIES-1:0] gone_reg;
    logic [31:0]        hits_reg;
    logic [31:0]        misses_reg;
    logic [31:0]        stales_reg;
    logic               rsp_valid_reg;
    tidt_rsp_t          rsp_reg;

    logic               rd_en;
    tidt_slot_t         rd_data;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    tidt_slot_t         wr_data;

    logic               cmp_used;
    logic               cmp_key_hit;
    logic               cmp_expired;
    logic [63:0]        cmp_age;
    logic               scan_stop;
    logic               finish_go;
    tidt_rsp_t          rsp_next;
    logic [31:0]        hits_next;
    logic [31:0]        misses_next;
    logic [31:0]        stales_next;
    logic [3:0]         len_sat;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // Slot memory, read by the scan and written by the finish step.
    tidt_slot_ram #(
        .DEPTH (TABLE_ENTRIES),
        .WIDTH ($bits(tidt_slot_t))
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_data)
    );

    assign rd_en = (state_reg == S_SCAN) && issue_reg;

    // Compare stage on the entry just read.
    always_comb
    begin
        cmp_used    = used_reg[cmp_idx_reg];
        cmp_key_hit = cmp_valid_reg && cmp_used && (rd_data.key == req_reg.group_key);
        cmp_age     = req_reg.time_ns - rd_data.removed;
        cmp_expired = cmp_valid_reg && cmp_used && gone_reg[cmp_idx_reg]
                      && (cmp_age > grace_reg);
        // The walk ends at the first key match (not for a tick), or after the last entry.
        scan_stop   = cmp_valid_reg
                      && ((cmp_key_hit && (req_reg.req_type != REQ_TICK))
                          || (cmp_idx_reg == LAST_IDX));
    end

    // Finish step: response contents and the table write.
    always_comb
    begin
        finish_go   = (state_reg == S_FINISH) && (!rsp_valid_reg || rsp_ready);
        len_sat     = (req_reg.step_length > 4'(STEP_BYTES)) ? 4'(STEP_BYTES)
                                                              : req_reg.step_length;
        hits_next   = hits_reg;
        misses_next = misses_reg;
        stales_next = stales_reg;
        rsp_next    = '0;
        rsp_next.status = ST_DONE;
        wr_en       = 1'b0;
        wr_addr     = match_found_reg ? match_idx_reg : free_idx_reg;
        wr_data     = hit_data_reg;
        case (req_reg.req_type)
            REQ_CREATE:
            begin
                wr_data.key        = req_reg.group_key;
                wr_data.job        = req_reg.job_number;
                wr_data.step_len   = len_sat;
                wr_data.step_bytes = req_reg.step_name & step_mask(len_sat);
                wr_data.task_flag  = req_reg.task_present;
                wr_data.task_num   = req_reg.task_present ? req_reg.task_number : 32'd0;
                wr_data.created    = req_reg.time_ns;
                wr_data.removed    = 64'd0;
                if (match_found_reg || free_found_reg)
                begin
                    wr_en = finish_go;
                end
                else
                begin
                    rsp_next.status = ST_FULL;
                end
            end
            REQ_REMOVE:
            begin
                wr_data.removed = req_reg.time_ns;
                wr_en = finish_go && match_found_reg && !gone_reg[match_idx_reg];
            end
            REQ_RESOLVE:
            begin
                if (!match_found_reg)
                begin
                    misses_next     = misses_reg + 32'd1;
                    rsp_next.status = ST_MISS;
                end
                else if ((req_reg.time_ns != 64'd0)
                         && (req_reg.time_ns < hit_data_reg.created))
                begin
                    stales_next     = stales_reg + 32'd1;
                    rsp_next.status = ST_STALE;
                end
                else
                begin
                    hits_next                   = hits_reg + 32'd1;
                    rsp_next.status             = ST_HIT;
                    rsp_next.found_job          = hit_data_reg.job;
                    rsp_next.found_step_length  = hit_data_reg.step_len;
                    rsp_next.found_step_name    = hit_data_reg.step_bytes;
                    rsp_next.found_task_present = hit_data_reg.task_flag;
                    rsp_next.found_task         = hit_data_reg.task_num;
                end
            end
            default:
            begin
                // A tick has already applied its expiry during the scan.
            end
        endcase
        rsp_next.hit_total   = hits_next;
        rsp_next.miss_total  = misses_next;
        rsp_next.stale_total = stales_next;
    end

    // Sequencer, table flags, counters and the response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            req_reg         <= '0;
            grace_reg       <= 64'd0;
            rd_idx_reg      <= '0;
            issue_reg       <= 1'b0;
            cmp_idx_reg     <= '0;
            cmp_valid_reg   <= 1'b0;
            match_found_reg <= 1'b0;
            match_idx_reg   <= '0;
            free_found_reg  <= 1'b0;
            free_idx_reg    <= '0;
            hit_data_reg    <= '0;
            used_reg        <= '0;
            gone_reg        <= '0;
            hits_reg        <= 32'd0;
            misses_reg      <= 32'd0;
            stales_reg      <= 32'd0;
            rsp_valid_reg   <= 1'b0;
            rsp_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                grace_reg <= cfg_wdata;
            end

            // The response register is loaded by the finish step and
            // emptied by its transfer.
            if (finish_go)
            begin
                rsp_reg       <= rsp_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        req_reg         <= req_data;
                        rd_idx_reg      <= '0;
                        issue_reg       <= 1'b1;
                        cmp_valid_reg   <= 1'b0;
                        match_found_reg <= 1'b0;
                        free_found_reg  <= 1'b0;
                        state_reg       <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    // Compare stage: expiry, free slot and key match.
                    if (cmp_valid_reg)
                    begin
                        if ((req_reg.req_type == REQ_TICK) && cmp_expired)
                        begin
                            used_reg[cmp_idx_reg] <= 1'b0;
                        end
                        if (!cmp_used && !free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= cmp_idx_reg;
                        end
                        if (cmp_key_hit && (req_reg.req_type != REQ_TICK))
                        begin
                            match_found_reg <= 1'b1;
                            match_idx_reg   <= cmp_idx_reg;
                            hit_data_reg    <= rd_data;
                        end
                    end
                    // Read stage: step through the table addresses until
                    // the compare stage ends the walk.
                    if (scan_stop)
                    begin
                        issue_reg     <= 1'b0;
                        cmp_valid_reg <= 1'b0;
                        state_reg     <= S_FINISH;
                    end
                    else
                    begin
                        cmp_valid_reg <= rd_en;
                        cmp_idx_reg   <= rd_idx_reg;
                        if (rd_en)
                        begin
                            if (rd_idx_reg == LAST_IDX)
                            begin
                                issue_reg <= 1'b0;
                            end
                            else
                            begin
                                rd_idx_reg <= rd_idx_reg + 1'b1;
                            end
                        end
                    end
                end
                S_FINISH:
                begin
                    if (finish_go)
                    begin
                        if (wr_en)
                        begin
                            used_reg[wr_addr] <= 1'b1;
                            gone_reg[wr_addr] <= (req_reg.req_type == REQ_REMOVE);
                        end
                        hits_reg      <= hits_next;
                        misses_reg    <= misses_next;
                        stales_reg    <= stales_next;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/tidt_slot_ram.sv
// ----------------------------------------------------------------------------
// tidt_slot_ram: simple dual-port table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tidt_slot_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/tidt_checker.sv
// ----------------------------------------------------------------------------
// tidt_checker: port-level checks for the timestamped id table
// Watches the request and response channels and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tidt_checker
    import tidt_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      req_valid,
    input wire logic      req_ready,
    input wire logic      rsp_valid,
    input wire logic      rsp_ready,
    input wire tidt_rsp_t rsp_data
);

    // A stalled response holds its payload.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("response changed while stalled");

    // After a request transfer the block is busy walking the table.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while a walk is in progress");

    // Only a hit carries identity fields.
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.status != ST_HIT) |->
            (rsp_data.found_job == 32'd0) && (rsp_data.found_step_length == 4'd0)
            && (rsp_data.found_step_name == 64'd0)
            && !rsp_data.found_task_present && (rsp_data.found_task == 32'd0))
        else $error("identity fields set on a non-hit response");

    // A hit reports a stored length that was saturated on create.
    a_hit_len: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.status == ST_HIT) |->
            (rsp_data.found_step_length <= 4'(STEP_BYTES)))
        else $error("hit step length beyond the stored maximum");

endmodule

bind timestamped_id_table_with_grace_unit tidt_checker u_tidt_checker (.*);

`default_nettype wire

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the timestamped id table unit
// Drives create, remove, tick and resolve requests through the valid/ready
// request port, keeps a shadow copy of the table and its counters to work out
// each response, and compares every response transfer field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import tidt_pkg::*;

    localparam int          CYCLE_LIMIT  = 1200000;
    localparam int          MAX_REPORTS  = 10;
    localparam int          KEY_POOL_MAX = 96;
    localparam logic [63:0] ALL_ONES     = {64{1'b1}};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [63:0] cfg_wdata = '0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    tidt_req_t   req_data = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    tidt_rsp_t   rsp_data;

    // Shadow copy of the table, the grace register and the counters.
    tidt_slot_t  shadow_slot [TABLE_ENTRIES];
    logic        shadow_used [TABLE_ENTRIES];
    logic        shadow_gone [TABLE_ENTRIES];
    logic [63:0] shadow_grace = '0;
    logic [31:0] shadow_hits = '0;
    logic [31:0] shadow_misses = '0;
    logic [31:0] shadow_stales = '0;

    tidt_rsp_t   pending_rsps [$];
    int unsigned failures = 0;
    int unsigned cycle_count = 0;

    // Stimulus state: a pool of reusable keys and a running clock.
    logic [63:0] key_pool [KEY_POOL_MAX];
    logic [63:0] now_ns = '0;

    timestamped_id_table_with_grace_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    always #5 clk = ~clk;

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Response stall pattern: always ready, coin flips, sparse ready, or a
    // fixed duty cycle, each held for a random stretch.
    int unsigned ready_mode = 0;
    int unsigned ready_mode_left = 0;
    int unsigned ready_phase = 0;
    always @(posedge clk)
    begin
        if (ready_mode_left == 0)
        begin
            ready_mode = $urandom_range(0, 3);
            ready_mode_left = $urandom_range(16, 400);
        end
        else
        begin
            ready_mode_left--;
        end
        ready_phase++;
        case (ready_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= 1'($urandom_range(0, 1));
            2:       rsp_ready <= ($urandom_range(0, 7) == 0);
            default: rsp_ready <= ((ready_phase % 37) < 5);
        endcase
    end

    // Lowest used slot holding the key, or -1.
    function automatic int lookup_slot(input logic [63:0] key);
        int i;
        for (i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (shadow_used[i] && shadow_slot[i].key == key)
                return i;
        end
        return -1;
    endfunction

    // Applies one request to the shadow table and returns the response it
    // should produce.
    function automatic tidt_rsp_t apply_request(input tidt_req_t r);
        tidt_rsp_t   rsp;
        int          slot;
        int          i;
        int unsigned len;
        logic [63:0] age;
        rsp = '0;
        rsp.status = ST_DONE;
        slot = lookup_slot(r.group_key);
        case (r.req_type)
            REQ_CREATE:
            begin
                len = (r.step_length > STEP_BYTES) ? STEP_BYTES : r.step_length;
                for (i = 0; i < TABLE_ENTRIES && slot < 0; i++)
                begin
                    if (!shadow_used[i])
                        slot = i;
                end
                if (slot < 0)
                begin
                    rsp.status = ST_FULL;
                end
                else
                begin
                    shadow_used[slot] = 1'b1;
                    shadow_gone[slot] = 1'b0;
                    shadow_slot[slot].key = r.group_key;
                    shadow_slot[slot].job = r.job_number;
                    shadow_slot[slot].step_len = 4'(len);
                    // Bytes past the stored length are kept as zero.
                    shadow_slot[slot].step_bytes = (len >= 8) ? r.step_name :
                        r.step_name & ((64'd1 << (8 * len)) - 64'd1);
                    shadow_slot[slot].task_flag = r.task_present;
                    shadow_slot[slot].task_num = r.task_present ? r.task_number : 32'd0;
                    shadow_slot[slot].created = r.time_ns;
                    shadow_slot[slot].removed = '0;
                end
            end
            REQ_REMOVE:
            begin
                // Only the first removal of an entry is stamped.
                if (slot >= 0 && !shadow_gone[slot])
                begin
                    shadow_gone[slot] = 1'b1;
                    shadow_slot[slot].removed = r.time_ns;
                end
            end
            REQ_TICK:
            begin
                for (i = 0; i < TABLE_ENTRIES; i++)
                begin
                    age = r.time_ns - shadow_slot[i].removed;
                    if (shadow_used[i] && shadow_gone[i] && age > shadow_grace)
                        shadow_used[i] = 1'b0;
                end
            end
            default:
            begin
                if (slot < 0)
                begin
                    shadow_misses++;
                    rsp.status = ST_MISS;
                end
                else if (r.time_ns != 64'd0 && r.time_ns < shadow_slot[slot].created)
                begin
                    shadow_stales++;
                    rsp.status = ST_STALE;
                end
                else
                begin
                    shadow_hits++;
                    rsp.status = ST_HIT;
                    rsp.found_job = shadow_slot[slot].job;
                    rsp.found_step_length = shadow_slot[slot].step_len;
                    rsp.found_step_name = shadow_slot[slot].step_bytes;
                    rsp.found_task_present = shadow_slot[slot].task_flag;
                    rsp.found_task = shadow_slot[slot].task_num;
                end
            end
        endcase
        rsp.hit_total = shadow_hits;
        rsp.miss_total = shadow_misses;
        rsp.stale_total = shadow_stales;
        return rsp;
    endfunction

    // Response checker: every transfer is matched against the oldest
    // expected response.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            check_response(rsp_data);
    end

    task automatic check_response(input tidt_rsp_t got);
        tidt_rsp_t want;
        logic      bad;
        if (pending_rsps.size() == 0)
        begin
            failures++;
            if (failures <= MAX_REPORTS)
                $display("unexpected response, status %0d", got.status);
            return;
        end
        want = pending_rsps.pop_front();
        bad = (got.status !== want.status) ||
              (got.found_job !== want.found_job) ||
              (got.found_step_length !== want.found_step_length) ||
              (got.found_step_name !== want.found_step_name) ||
              (got.found_task_present !== want.found_task_present) ||
              (got.found_task !== want.found_task) ||
              (got.hit_total !== want.hit_total) ||
              (got.miss_total !== want.miss_total) ||
              (got.stale_total !== want.stale_total);
        if (bad)
        begin
            failures++;
            if (failures <= MAX_REPORTS)
            begin
                $display("mismatch: exp st %0d job %h len %0d name %h tp %b task %h",
                    want.status, want.found_job, want.found_step_length,
                    want.found_step_name, want.found_task_present, want.found_task);
                $display("          got st %0d job %h len %0d name %h tp %b task %h",
                    got.status, got.found_job, got.found_step_length,
                    got.found_step_name, got.found_task_present, got.found_task);
                $display("          counters exp %0d/%0d/%0d got %0d/%0d/%0d",
                    want.hit_total, want.miss_total, want.stale_total,
                    got.hit_total, got.miss_total, got.stale_total);
            end
        end
    endtask

    // Presents one request and waits for its transfer. Valid stays high on
    // return so back-to-back requests need not drop it.
    task automatic send_request(input tidt_req_t r);
        req_valid <= 1'b1;
        req_data <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        pending_rsps.insert(pending_rsps.size(), apply_request(r));
    endtask

    // Holds off the sender until every expected response has arrived.
    task automatic drain_responses();
        req_valid <= 1'b0;
        while (pending_rsps.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_grace(input logic [63:0] value);
        drain_responses();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow_grace = value;
    endtask

    // Random gap between bursts: often none, sometimes short or long, and
    // now and then a full drain.
    task automatic sender_gap();
        int unsigned pick;
        int unsigned cycles;
        pick = $urandom_range(0, 9);
        cycles = 0;
        if (pick >= 4 && pick <= 7)
            cycles = $urandom_range(1, 8);
        else if (pick == 8)
            cycles = $urandom_range(9, 70);
        if (pick == 9)
        begin
            drain_responses();
        end
        else if (cycles != 0)
        begin
            req_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    function automatic tidt_req_t build_request(input logic [1:0] kind,
                                                input logic [63:0] key,
                                                input logic [63:0] stamp,
                                                input logic [31:0] job,
                                                input logic [3:0] len,
                                                input logic [63:0] name,
                                                input logic tp,
                                                input logic [31:0] task_num);
        tidt_req_t r;
        r.req_type = kind;
        r.group_key = key;
        r.time_ns = stamp;
        r.job_number = job;
        r.step_length = len;
        r.step_name = name;
        r.task_present = tp;
        r.task_number = task_num;
        return r;
    endfunction

    // Mostly well-formed traffic on pooled keys with an advancing clock,
    // mixed with random keys and random times.
    function automatic tidt_req_t random_request(input int unsigned pool_n,
                                                 input int unsigned create_pct);
        tidt_req_t   r;
        int unsigned pick;
        r = build_request(REQ_RESOLVE, key_pool[$urandom_range(0, pool_n - 1)], '0,
                          $urandom, 4'($urandom_range(0, 15)), {$urandom, $urandom},
                          1'($urandom_range(0, 1)), $urandom);
        now_ns = now_ns + 64'($urandom_range(0, 40));
        r.time_ns = now_ns;
        if ($urandom_range(0, 99) < create_pct)
        begin
            r.req_type = REQ_CREATE;
            // Some entries are created in the future so resolves come back stale.
            if ($urandom_range(0, 4) == 0)
                r.time_ns = now_ns + 64'($urandom_range(1, 300));
        end
        else
        begin
            pick = $urandom_range(0, 3);
            if (pick == 0)
                r.req_type = REQ_REMOVE;
            else if (pick == 1)
                r.req_type = REQ_TICK;
            else
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    r.time_ns = '0;
                else if (pick <= 2)
                    r.time_ns = now_ns - 64'($urandom_range(1, 400));
            end
        end
        if ($urandom_range(0, 19) == 0)
            r.group_key = {$urandom, $urandom};
        if ($urandom_range(0, 19) == 0)
            r.time_ns = {$urandom, $urandom};
        return r;
    endfunction

    // Named corner cases: empty table, saturation, stale, replace, removal
    // at time zero, repeated and unknown removes, expiry and its wrap.
    task automatic test_directed_cases();
        logic [63:0] k;
        k = 64'h5555_AAAA_0F0F_F0F0;
        set_grace('0);
        send_request(build_request(REQ_RESOLVE, '0, '0, '0, '0, '0, 1'b0, '0));
        send_request(build_request(REQ_CREATE, '0, '0, '1, 4'hF, ALL_ONES, 1'b1, '1));
        send_request(build_request(REQ_RESOLVE, '0, '0, '0, '0, '0, 1'b0, '0));
        send_request(build_request(REQ_CREATE, ALL_ONES, ALL_ONES, '0, 4'd3, ALL_ONES,
                                   1'b0, '1));
        send_request(build_request(REQ_RESOLVE, ALL_ONES, 64'd1, '0, '0, '0, 1'b0, '0));
        send_request(build_request(REQ_RESOLVE, ALL_ONES, '0, '0, '0, '0, 1'b0, '0));
        send_request(build_request(REQ_RESOLVE, ALL_ONES, ALL_ONES, '0, '0, '0, 1'b0, '0));
        send_request(build_request(REQ_CREATE, '0, 64'd100, 32'd5, 4'd0,
                                   64'hA5A5_A5A5_A5A5_A5A5, 1'b1, 32'd7));
        send_request(build_request(REQ_RESOLVE, '0, 64'd50, '0, '0, '0, 1'b0, '0));
        send_request(build_request(REQ_REMOVE, '0, '0, '0, '0, '0, 1'b0, '0));
        send_request(build_request(REQ_REMOVE, '0, 64'd500, '0, '0, '0, 1'b0, '0));
        send_request(build_request(REQ_TICK, '0, '0, '0, '0, '0, 1'b0, '0));
        send_request(build_request(REQ_RESOLVE, '0, 64'd200, '0, '0, '0, 1'b0, '0));
        send_request(build_request(REQ_TICK, '0, 64'd1, '0, '0, '0, 1'b0, '0));
        send_request(build_request(REQ_RESOLVE, '0, 64'd200, '0, '0, '0, 1'b0, '0));
        send_request(build_request(REQ_REMOVE, 64'h1234, 64'd3, '0, '0, '0, 1'b0, '0));
        send_request(build_request(REQ_REMOVE, ALL_ONES, 64'd10, '0, '0, '0, 1'b0, '0));
        // Current time below the removal time wraps to a huge age.
        send_request(build_request(REQ_TICK, '0, 64'd5, '0, '0, '0, 1'b0, '0));
        send_request(build_request(REQ_RESOLVE, ALL_ONES, '0, '0, '0, '0, 1'b0, '0));
        // A create on a removed entry clears its removal mark.
        send_request(build_request(REQ_CREATE, k, 64'd20, $urandom, 4'd8,
                                   {$urandom, $urandom}, 1'b1, $urandom));
        send_request(build_request(REQ_REMOVE, k, 64'd30, '0, '0, '0, 1'b0, '0));
        send_request(build_request(REQ_CREATE, k, 64'd40, $urandom, 4'd9,
                                   {$urandom, $urandom}, 1'b0, $urandom));
        send_request(build_request(REQ_TICK, '0, ALL_ONES, '0, '0, '0, 1'b0, '0));
        send_request(build_request(REQ_RESOLVE, k, 64'd40, '0, '0, '0, 1'b0, '0));
        drain_responses();
    endtask

    // Fills every free slot with fresh keys, overflows the table, then frees them again.
    task automatic test_table_full();
        logic [63:0] fresh [TABLE_ENTRIES + 2];
        int          i;
        set_grace('0);
        for (i = 0; i < TABLE_ENTRIES + 2; i++)
        begin
            fresh[i] = {$urandom, $urandom};
            now_ns = now_ns + 64'd1;
            send_request(build_request(REQ_CREATE, fresh[i], now_ns, $urandom,
                                       4'($urandom_range(0, 15)), {$urandom, $urandom},
                                       1'($urandom_range(0, 1)), $urandom));
        end
        send_request(build_request(REQ_RESOLVE, fresh[TABLE_ENTRIES + 1], now_ns,
                                   '0, '0, '0, 1'b0, '0));
        for (i = 0; i < TABLE_ENTRIES + 2; i++)
            send_request(build_request(REQ_REMOVE, fresh[i], now_ns, '0, '0, '0, 1'b0, '0));
        send_request(build_request(REQ_TICK, '0, now_ns + 64'd1, '0, '0, '0, 1'b0, '0));
        drain_responses();
    endtask

    // Random bursts under one grace setting.
    task automatic test_random_traffic(input int unsigned count,
                                       input logic [63:0] grace,
                                       input int unsigned pool_n,
                                       input int unsigned create_pct);
        int unsigned sent;
        int unsigned burst;
        set_grace(grace);
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 24);
            while (burst != 0 && sent < count)
            begin
                send_request(random_request(pool_n, create_pct));
                sent++;
                burst--;
            end
            sender_gap();
        end
        drain_responses();
    endtask

    // Same traffic with the clock starting just below its wrap point.
    task automatic test_clock_wrap(input int unsigned count, input logic [63:0] grace);
        now_ns = 64'hFFFF_FFFF_FFFF_F000;
        test_random_traffic(count, grace, 40, 30);
    endtask

    initial
    begin
        int i;
        for (i = 0; i < TABLE_ENTRIES; i++)
        begin
            shadow_used[i] = 1'b0;
            shadow_gone[i] = 1'b0;
            shadow_slot[i] = '0;
        end
        key_pool[0] = '0;
        key_pool[1] = ALL_ONES;
        for (i = 2; i < KEY_POOL_MAX; i++)
            key_pool[i] = {$urandom, $urandom};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_table_full();
        test_random_traffic(300, '0, 24, 30);
        test_random_traffic(300, 64'd50, 24, 30);
        test_random_traffic(250, ALL_ONES, KEY_POOL_MAX, 60);
        test_random_traffic(200, {$urandom, $urandom}, KEY_POOL_MAX, 40);
        test_clock_wrap(250, 64'd400);
        test_random_traffic(200, 64'd1, 16, 30);

        // Let any stray response show up before the verdict.
        drain_responses();
        repeat (TABLE_ENTRIES + 8) @(posedge clk);
        failures += pending_rsps.size();
        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
